/* src/prewitt_edge_magnitude_filter_macros.svh */
// Assertion macros shared by the edge filter modules.
// Each use expects clk and rst in scope.
`ifndef PREWITT_EDGE_MAGNITUDE_FILTER_MACROS_SVH
`define PREWITT_EDGE_MAGNITUDE_FILTER_MACROS_SVH

// consequence in the same cycle
`define PEF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequence in the following cycle
`define PEF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/pef_pkg.sv */
// Shared types, constants and elaboration-time tables for the edge filter.
// No dependencies.
package pef_pkg;

  localparam int MAX_WIDTH = 4096;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int CNT_W     = COL_W + 1;
  localparam int WID_W     = 13;
  localparam int HGT_W     = 16;
  localparam int ROW_W     = HGT_W + 1;
  localparam int OWED_W    = $clog2(MAX_WIDTH + 2);
  localparam int LUMA_W    = 24;
  localparam int LINE_W    = 2 * LUMA_W;
  localparam int GSUM_W    = LUMA_W + 2;
  localparam int SQ_W      = 2 * GSUM_W;
  localparam int ROOT_W    = GSUM_W + 1;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int MAG_SHIFT = 8;
  localparam int MAG_W     = ROOT_W - MAG_SHIFT;
  localparam int THR_W     = 13;
  localparam int LEVEL_W   = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 16;

  localparam int SAT_MAG = 4437;
  localparam longint unsigned E_INV_Q32 = 64'd1580030169;

  localparam logic [15:0] LUMA_WR = 16'd13933;
  localparam logic [15:0] LUMA_WG = 16'd46871;
  localparam logic [15:0] LUMA_WB = 16'd4732;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } pef_cfg_idx_t;

  typedef struct packed {
    logic       command;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pef_in_t;

  typedef struct packed {
    logic [7:0] edge_res;
    logic       last;
  } pef_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } pef_unit_st_t;

  typedef logic [2:0][2:0][LUMA_W-1:0] pef_win_t;

  function automatic logic [LUMA_W-1:0] luma(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
    logic [LUMA_W-1:0] pr, pg, pb;
    pr = LUMA_W'(LUMA_WR) * LUMA_W'(r);
    pg = LUMA_W'(LUMA_WG) * LUMA_W'(g);
    pb = LUMA_W'(LUMA_WB) * LUMA_W'(b);
    return pr + pg + pb;
  endfunction

  // restoring shift-subtract quotient, quotient known to fit in qbits
  function automatic longint unsigned udiv_c(input longint unsigned a,
                                             input longint unsigned b, input int qbits);
    longint unsigned rem, q;
    int i;
    rem = a;
    q = 64'd0;
    for (i = qbits - 1; i >= 0; i--) begin
      if (rem >= (b << i)) begin
        rem = rem - (b << i);
        q = q | (64'd1 << i);
      end
    end
    return q;
  endfunction

  // smallest magnitude reaching each level of floor(255 * sigmoid(M / 256))
  function automatic logic [255:0][THR_W-1:0] build_level_thr();
    logic [255:0][THR_W-1:0] thr;
    longint unsigned ef [256];
    longint unsigned sum, term, y, lvl;
    int f, n, m, i, k;
    thr = '0;
    for (f = 0; f < 256; f++) begin
      sum = 64'd1 << 32;
      term = 64'd1 << 32;
      for (n = 1; n <= 20; n++) begin
        term = udiv_c((term * 64'(f)) >> 8, 64'(n), 41);
        if ((n & 1) != 0) sum = sum - term;
        else sum = sum + term;
      end
      ef[f] = sum;
    end
    k = 0;
    for (m = 0; m < SAT_MAG; m++) begin
      y = ef[m & 255];
      for (i = 0; i < (m >> 8); i++) y = (y * E_INV_Q32) >> 32;
      lvl = udiv_c(64'd255 << 32, (64'd1 << 32) + y, 9);
      if (lvl > 64'd255) lvl = 64'd255;
      while (k < 256 && k <= int'(lvl)) begin
        thr[k] = THR_W'(m);
        k++;
      end
    end
    while (k < 256) begin
      thr[k] = THR_W'(SAT_MAG);
      k++;
    end
    return thr;
  endfunction

  localparam logic [255:0][THR_W-1:0] LEVEL_THR = build_level_thr();

endpackage

/* src/pef_ram.sv */
// Single-port line store with registered read data.
// No dependencies.
module pef_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

endmodule

/* src/pef_isqrt.sv */
// Integer square root, two radicand bits per cycle.
// Depends on pef_pkg and the macro header.
`include "prewitt_edge_magnitude_filter_macros.svh"
module pef_isqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [pef_pkg::RAD_W-1:0] radicand,
  output pef_pkg::pef_unit_st_t     status,
  output logic [pef_pkg::ROOT_W-1:0] root
);
  import pef_pkg::*;

  localparam int REM_W = ROOT_W + 2;
  localparam int CT_W  = $clog2(ROOT_W);

  logic [RAD_W-1:0] rad;
  logic [REM_W-1:0] rem;
  logic [CT_W-1:0]  cnt;
  logic [REM_W-1:0] rem_sh, trial;
  logic             fits;

  assign rem_sh = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
  assign trial  = {root, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
    end else begin
      status.done <= 1'b0;
      if (start && !status.busy) begin
        status.busy <= 1'b1;
      end else if (status.busy && cnt == CT_W'(ROOT_W - 1)) begin
        status.busy <= 1'b0;
        status.done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !status.busy) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
      cnt  <= '0;
    end else if (status.busy) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      rem  <= fits ? rem_sh - trial : rem_sh;
      root <= {root[ROOT_W-2:0], fits};
      cnt  <= cnt + 1'b1;
    end
  end

  `PEF_ASSERT_NEXT(a_sqrt_start, start && !status.busy, status.busy, "root unit did not start")
  `PEF_ASSERT_NEXT(a_sqrt_done, status.done, !status.busy, "root unit busy after done")
  `PEF_ASSERT_NOW(a_sqrt_rem, status.busy, rem <= {root, 1'b0}, "root remainder too large")

endmodule

/* src/pef_level.sv */
// Edge level from magnitude: binary search over the sigmoid threshold table.
// Depends on pef_pkg and the macro header.
`include "prewitt_edge_magnitude_filter_macros.svh"
module pef_level (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pef_pkg::MAG_W-1:0]   mag,
  output pef_pkg::pef_unit_st_t       status,
  output logic [pef_pkg::LEVEL_W-1:0] level
);
  import pef_pkg::*;

  localparam int STEP_W = $clog2(LEVEL_W);

  logic [THR_W-1:0]   mag_q;
  logic               sat;
  logic [STEP_W-1:0]  step;
  logic [LEVEL_W-1:0] cand;

  assign cand = level | (LEVEL_W'(1) << step);

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
    end else begin
      status.done <= 1'b0;
      if (start && !status.busy) begin
        status.busy <= 1'b1;
      end else if (status.busy && step == '0) begin
        status.busy <= 1'b0;
        status.done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !status.busy) begin
      sat   <= mag >= MAG_W'(SAT_MAG);
      mag_q <= mag[THR_W-1:0];
      level <= '0;
      step  <= STEP_W'(LEVEL_W - 1);
    end else if (status.busy) begin
      if (sat || LEVEL_THR[cand] <= mag_q) level <= cand;
      step <= step - 1'b1;
    end
  end

  `PEF_ASSERT_NEXT(a_lvl_done, status.done, !status.busy, "level search busy after done")
  `PEF_ASSERT_NEXT(a_lvl_start, start && !status.busy, status.busy, "level search did not start")

endmodule

/* src/prewitt_edge_magnitude_filter.sv */
// Prewitt edge-magnitude filter: luma, line store, 3x3 window, root and level.
// Depends on pef_pkg, pef_ram, pef_isqrt, pef_level and the macro header.
//
//  channel  dir  handshake           beat
//  pix      in   pix_valid/stall     pef_in_t: command, red, green, blue
//  res      out  res_valid/stall     pef_out_t: edge_res, last
//  cfg      in   cfg_we              cfg_index, cfg_data
//
// One item at a time. An item that yields a result passes through the 27-step
// square-root unit and then the 8-step threshold search. A flush that must step
// over a row end reads the line store twice. Reset is synchronous and needs no
// clearing pass. A finished beat moves into the output register before the
// next item is taken; while a finished beat waits on a stalled output register,
// the input stalls.
`include "prewitt_edge_magnitude_filter_macros.svh"
module prewitt_edge_magnitude_filter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pix_valid,
  output logic                          pix_stall,
  input  pef_pkg::pef_in_t              pix_data,
  output logic                          res_valid,
  input  logic                          res_stall,
  output pef_pkg::pef_out_t             res_data,
  input  logic                          cfg_we,
  input  logic [pef_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pef_pkg::CFG_W-1:0]     cfg_data
);
  import pef_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_COL   = 8'b0000_0010,
    S_RETRY = 8'b0000_0100,
    S_SQX   = 8'b0000_1000,
    S_SQY   = 8'b0001_0000,
    S_SUM   = 8'b0010_0000,
    S_ROOT  = 8'b0100_0000,
    S_LEVEL = 8'b1000_0000
  } pef_state_t;

  pef_state_t          state, state_next;
  logic [WID_W-1:0]    width;
  logic [HGT_W-1:0]    height;
  logic [WID_W-1:0]    w_eff;
  logic [HGT_W-1:0]    h_eff;
  logic [COL_W-1:0]    column_count;
  logic [ROW_W-1:0]    row_count;
  logic [OWED_W-1:0]   results_owed;
  pef_win_t            win;
  logic                cmd_q;
  logic [LUMA_W-1:0]   lum_q;
  logic                retried;
  logic                last_q;
  logic                done_wait;
  logic [GSUM_W-1:0]   ax, ay;
  logic [SQ_W-1:0]     px, py;
  logic [LINE_W-1:0]   rd_line, wr_line;
  logic                mem_we;
  logic                accept, take;

  logic [LUMA_W-1:0]        rd_upper, rd_mid, top_v, mid_v, bot_v;
  pef_win_t                 win_col;
  logic [2:0][LUMA_W-1:0]   col_l, col_c, col_r;
  logic                     emit, last_v;
  logic [GSUM_W-1:0]        sxl, sxr, syt, syb;
  logic [CNT_W-1:0]         col_inc;
  logic                     row_end;
  logic [ROW_W-1:0]         row_after;
  logic [LEVEL_W-1:0]       level;
  logic [ROOT_W-1:0]        root;
  pef_unit_st_t             sqrt_st, lvl_st;

  assign w_eff = (width == '0) ? WID_W'(1) :
                 (width > WID_W'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH) : width;
  assign h_eff = (height == '0) ? HGT_W'(1) : height;

  assign pix_stall = (state != S_IDLE) || done_wait;
  assign accept    = pix_valid && !pix_stall;

  pef_ram #(.DEPTH(MAX_WIDTH), .WIDTH(LINE_W)) u_line (
    .clk   (clk),
    .we    (mem_we),
    .addr  (column_count),
    .wdata (wr_line),
    .rdata (rd_line)
  );

  // column step: read back, choose window column, shift
  always_comb begin
    rd_upper = rd_line[LINE_W-1 -: LUMA_W];
    rd_mid   = rd_line[LUMA_W-1:0];
    mem_we   = 1'b0;
    wr_line  = {rd_mid, lum_q};
    if (cmd_q == CMD_PIXEL) begin
      mem_we = state == S_COL;
      if (row_count == '0) begin
        top_v   = lum_q;
        mid_v   = lum_q;
        bot_v   = lum_q;
        wr_line = {lum_q, lum_q};
      end else begin
        mid_v = rd_mid;
        top_v = (row_count == ROW_W'(1)) ? rd_mid : rd_upper;
        bot_v = lum_q;
      end
    end else begin
      mid_v = rd_mid;
      top_v = (row_count == ROW_W'(1)) ? rd_mid : rd_upper;
      bot_v = rd_mid;
    end

    if (column_count == '0) begin
      emit    = row_count >= ROW_W'(2);
      last_v  = row_count == ROW_W'(h_eff) + ROW_W'(1);
      col_l   = win[1];
      col_c   = win[2];
      col_r   = win[2];
      win_col = {3{{bot_v, mid_v, top_v}}};
    end else begin
      emit    = row_count >= ROW_W'(1);
      last_v  = 1'b0;
      win_col = {{bot_v, mid_v, top_v}, win[2], win[1]};
      col_l   = win_col[0];
      col_c   = win_col[1];
      col_r   = win_col[2];
    end

    sxl = GSUM_W'(col_l[0]) + GSUM_W'(col_l[1]) + GSUM_W'(col_l[2]);
    sxr = GSUM_W'(col_r[0]) + GSUM_W'(col_r[1]) + GSUM_W'(col_r[2]);
    syt = GSUM_W'(col_l[0]) + GSUM_W'(col_c[0]) + GSUM_W'(col_r[0]);
    syb = GSUM_W'(col_l[2]) + GSUM_W'(col_c[2]) + GSUM_W'(col_r[2]);

    col_inc   = CNT_W'(column_count) + CNT_W'(1);
    row_end   = col_inc >= CNT_W'(w_eff);
    row_after = row_end ? row_count + ROW_W'(1) : row_count;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if ((pix_data.command == CMD_PIXEL && results_owed == '0) ||
              (pix_data.command == CMD_FLUSH && results_owed != '0)) begin
            state_next = S_COL;
          end
        end
      end
      S_COL: begin
        if (emit) state_next = S_SQX;
        else if (cmd_q == CMD_FLUSH && !retried) state_next = S_RETRY;
        else state_next = S_IDLE;
      end
      S_RETRY: state_next = S_COL;
      S_SQX:   state_next = S_SQY;
      S_SQY:   state_next = S_SUM;
      S_SUM:   state_next = S_ROOT;
      S_ROOT:  if (sqrt_st.done) state_next = S_LEVEL;
      S_LEVEL: if (lvl_st.done) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign take = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      width        <= WID_W'(MAX_WIDTH);
      height       <= HGT_W'(1);
      column_count <= '0;
      row_count    <= '0;
      results_owed <= '0;
      win          <= '0;
      retried      <= 1'b0;
      res_valid    <= 1'b0;
      done_wait    <= 1'b0;
    end else begin
      state <= state_next;
      if (res_valid && !res_stall) res_valid <= 1'b0;
      if (state == S_LEVEL && lvl_st.done) done_wait <= 1'b1;
      if (done_wait && take) begin
        res_valid <= 1'b1;
        done_wait <= 1'b0;
      end
      if (state == S_IDLE) retried <= 1'b0;
      if (state == S_RETRY) retried <= 1'b1;
      if (state == S_COL) begin
        win          <= win_col;
        column_count <= row_end ? '0 : col_inc[COL_W-1:0];
        row_count    <= row_after;
        if (cmd_q == CMD_PIXEL) begin
          if (row_after >= ROW_W'(h_eff)) begin
            results_owed <= (h_eff == HGT_W'(1)) ? OWED_W'(w_eff) :
                            OWED_W'(w_eff) + OWED_W'(1);
          end
        end else if (emit) begin
          results_owed <= results_owed - OWED_W'(1);
          if (last_v) begin
            column_count <= '0;
            row_count    <= '0;
            results_owed <= '0;
            win          <= '0;
          end
        end
      end
      if (cfg_we) begin
        unique case (pef_cfg_idx_t'(cfg_index))
          CFG_WIDTH:  width  <= cfg_data[WID_W-1:0];
          CFG_HEIGHT: height <= cfg_data[HGT_W-1:0];
          default:    width  <= width;
        endcase
        column_count <= '0;
        row_count    <= '0;
        results_owed <= '0;
        win          <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= pix_data.command;
      lum_q <= luma(pix_data.red, pix_data.green, pix_data.blue);
    end
    if (state == S_COL) begin
      last_q <= last_v;
      ax     <= (sxl >= sxr) ? sxl - sxr : sxr - sxl;
      ay     <= (syt >= syb) ? syt - syb : syb - syt;
    end
    if (state == S_SQX) px <= ax * ax;
    if (state == S_SQY) py <= ay * ay;
    if (done_wait && take) begin
      res_data.edge_res <= level;
      res_data.last     <= last_q;
    end
  end

  pef_isqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_SUM),
    .radicand (RAD_W'(px) + RAD_W'(py)),
    .status   (sqrt_st),
    .root     (root)
  );

  pef_level u_level (
    .clk    (clk),
    .rst    (rst),
    .start  (state == S_ROOT && sqrt_st.done),
    .mag    (root[ROOT_W-1:MAG_SHIFT]),
    .status (lvl_st),
    .level  (level)
  );

  `PEF_ASSERT_NOW(a_col_bound, 1'b1, COL_W'(column_count) < w_eff, "column beyond row width")
  `PEF_ASSERT_NOW(a_owed_bound, 1'b1, results_owed <= OWED_W'(w_eff) + OWED_W'(1), "owed too large")
  `PEF_ASSERT_NEXT(a_wait_free, done_wait && take, res_valid && !done_wait, "finished beat not loaded")

endmodule

/* test/tb_prewitt_edge_magnitude_filter.sv */
// Self-checking testbench for prewitt_edge_magnitude_filter: raster images of many
// sizes and pixel values are streamed in and each edge level is checked against a
// local predictor of luma, 3x3 Prewitt window, root magnitude and level. Needs pef_pkg.
`timescale 1ns / 1ps
module tb_prewitt_edge_magnitude_filter;
  import pef_pkg::*;

  localparam int MAXW = 4096;
  localparam longint unsigned E_INV = 64'd1580030169;
  localparam int CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pix_valid = 1'b0;
  logic pix_stall;
  pef_in_t pix_data = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  pef_out_t res_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;

  prewitt_edge_magnitude_filter DUT (
    .clk(clk), .rst(rst),
    .pix_valid(pix_valid), .pix_stall(pix_stall), .pix_data(pix_data),
    .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  pef_in_t pixel_q[$];
  pef_out_t level_q[$];
  int errors = 0;
  int beats_in = 0;
  int beats_issued = 0;
  int beats_out = 0;
  int images = 0;
  int cycles = 0;
  bit idle_on = 1'b1;

  task automatic queue_item(pef_in_t b);
    pixel_q.insert(pixel_q.size(), b);
  endtask

  // predictor state
  int unsigned img_w = 4096;
  int unsigned img_h = 1;
  logic [23:0] upper_store [MAXW];
  logic [23:0] middle_store [MAXW];
  logic [23:0] win [9];
  int unsigned col_pos, row_pos, owed;

  function automatic int unsigned eff_w();
    if (img_w < 1) return 1;
    if (img_w > MAXW) return MAXW;
    return img_w;
  endfunction

  function automatic int unsigned eff_h();
    return (img_h == 0) ? 1 : img_h;
  endfunction

  function automatic longint unsigned root_of(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else r = r >> 1;
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [7:0] edge_level(longint l0, longint l1, longint l2,
                                            longint c0, longint c2,
                                            longint r0, longint r1, longint r2);
    longint gx, gy;
    longint unsigned ax, ay, mag, sum, term, y, lvl;
    int unsigned f, i, n;
    gx = (l0 + l1 + l2) - (r0 + r1 + r2);
    gy = (l0 + c0 + r0) - (l2 + c2 + r2);
    ax = (gx < 0) ? -gx : gx;
    ay = (gy < 0) ? -gy : gy;
    mag = root_of(ax * ax + ay * ay) >> 8;
    if (mag > 262143) mag = 262143;
    if (mag >= 4437) return 8'd255;
    f = mag & 255;
    i = mag >> 8;
    sum = 64'd1 << 32;
    term = 64'd1 << 32;
    for (n = 1; n <= 20; n++) begin
      term = term * f / (64'd256 * n);
      if (n & 1) sum = sum - term;
      else sum = sum + term;
    end
    y = sum;
    for (n = 0; n < i; n++) y = (y * E_INV) >> 32;
    lvl = (64'd255 << 32) / ((64'd1 << 32) + y);
    return (lvl > 255) ? 8'd255 : lvl[7:0];
  endfunction

  task automatic clear_image();
    col_pos = 0;
    row_pos = 0;
    owed = 0;
    foreach (win[k]) win[k] = '0;
  endtask

  task automatic shift_column(logic [23:0] t, logic [23:0] m, logic [23:0] b,
                              output bit emit, output pef_out_t r);
    emit = 1'b0;
    r = '0;
    if (col_pos == 0) begin
      if (row_pos >= 2) begin
        emit = 1'b1;
        r.edge_res = edge_level(win[3], win[4], win[5], win[6], win[8],
                                win[6], win[7], win[8]);
        r.last = (row_pos - 2 == eff_h() - 1);
      end
      win[0] = t; win[3] = t; win[6] = t;
      win[1] = m; win[4] = m; win[7] = m;
      win[2] = b; win[5] = b; win[8] = b;
    end else begin
      for (int k = 0; k < 6; k++) win[k] = win[k+3];
      win[6] = t; win[7] = m; win[8] = b;
      if (row_pos >= 1) begin
        emit = 1'b1;
        r.edge_res = edge_level(win[0], win[1], win[2], win[3], win[5],
                                win[6], win[7], win[8]);
      end
    end
    col_pos++;
    if (col_pos >= eff_w()) begin
      col_pos = 0;
      row_pos++;
    end
  endtask

  task automatic predict_beat(pef_in_t a);
    logic [23:0] lum, t, m, b;
    int unsigned idx;
    bit emit;
    pef_out_t r;
    emit = 1'b0;
    idx = (col_pos < MAXW) ? col_pos : 0;
    if (a.command == CMD_PIXEL) begin
      if (owed != 0) return;
      lum = 24'(13933 * a.red + 46871 * a.green + 4732 * a.blue);
      if (row_pos == 0) begin
        t = lum; m = lum; b = lum;
        upper_store[idx] = lum;
      end else begin
        m = middle_store[idx];
        t = (row_pos == 1) ? m : upper_store[idx];
        b = lum;
        upper_store[idx] = m;
      end
      middle_store[idx] = lum;
      shift_column(t, m, b, emit, r);
      if (row_pos >= eff_h()) owed = (eff_h() == 1) ? eff_w() : eff_w() + 1;
    end else begin
      if (owed == 0) return;
      for (int k = 0; k < 2 && !emit; k++) begin
        idx = (col_pos < MAXW) ? col_pos : 0;
        m = middle_store[idx];
        t = (row_pos == 1) ? m : upper_store[idx];
        shift_column(t, m, m, emit, r);
      end
      if (emit) owed--;
      if (r.last) begin
        clear_image();
        images++;
      end
    end
    if (emit) level_q.insert(level_q.size(), r);
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && pix_valid && !pix_stall) begin
      predict_beat(pix_data);
      beats_in <= beats_in + 1;
    end
    if (!rst && res_valid && !res_stall) begin
      beats_out <= beats_out + 1;
      if (level_q.size() == 0) begin
        $error("unexpected beat edge_res=%0d last=%0d", res_data.edge_res, res_data.last);
        errors++;
      end else begin
        if (res_data.edge_res !== level_q[0].edge_res) begin
          $error("edge_res expected %0d actual %0d", level_q[0].edge_res, res_data.edge_res);
          errors++;
        end
        if (res_data.last !== level_q[0].last) begin
          $error("last expected %0d actual %0d", level_q[0].last, res_data.last);
          errors++;
        end
        void'(level_q.pop_front());
      end
    end
  end

  int send_gap = 0;
  always @(negedge clk) begin
    if (rst) pix_valid <= 1'b0;
    else if (!pix_valid || beats_in == beats_issued) begin
      if (send_gap > 0) begin
        send_gap--;
        pix_valid <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        pix_data <= pixel_q.pop_front();
        pix_valid <= 1'b1;
        beats_issued++;
        send_gap = idle_on ? $urandom_range(0, 4) : 0;
      end else pix_valid <= 1'b0;
    end
  end

  int hold_left = 0;
  int seen_out = 0;
  bit long_done = 1'b0;
  always @(negedge clk) begin
    if (beats_out != seen_out) begin
      seen_out = beats_out;
      hold_left = idle_on ? $urandom_range(0, 4) : 0;
      if (!long_done && seen_out >= 40) begin
        long_done = 1'b1;
        hold_left = 600;
      end
    end
    res_stall <= !rst && hold_left > 0;
    if (hold_left > 0) hold_left--;
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("[prewitt_edge_magnitude_filter] ERROR");
      $finish;
    end
  end

  task automatic write_reg(pef_cfg_idx_t idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_WIDTH) img_w = val & 16'h1FFF;
    else img_h = val;
    clear_image();
  endtask

  task automatic wait_drained();
    wait (pixel_q.size() == 0 && beats_in == beats_issued && level_q.size() == 0);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [7:0] chan();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic pef_in_t rand_pixel();
    pef_in_t p;
    p.command = CMD_PIXEL;
    p.red = chan();
    p.green = chan();
    p.blue = chan();
    return p;
  endfunction

  function automatic pef_in_t flush_beat();
    pef_in_t p;
    p = '0;
    p.command = CMD_FLUSH;
    p.red = 8'($urandom);
    p.green = 8'($urandom);
    p.blue = 8'($urandom);
    return p;
  endfunction

  // one full image of random pixels, stray beats mixed in, then enough flushes
  task automatic queue_image(int unsigned w, int unsigned h, bit noise);
    for (int unsigned k = 0; k < w * h; k++) begin
      if (noise && $urandom_range(0, 15) == 0) queue_item(flush_beat());
      queue_item(rand_pixel());
    end
    if (noise && $urandom_range(0, 1)) queue_item(rand_pixel());
    for (int unsigned k = 0; k < ((h == 1) ? w : w + 1) + 2; k++)
      queue_item(flush_beat());
  endtask

  pef_in_t p;
  int unsigned w, h;
  initial begin
    foreach (upper_store[k]) begin
      upper_store[k] = '0;
      middle_store[k] = '0;
    end
    clear_image();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: 3x3 of extremes, stray flush first, stray pixel while draining
    write_reg(CFG_WIDTH, CFG_W'(3));
    write_reg(CFG_HEIGHT, CFG_W'(3));
    queue_item(flush_beat());
    for (int k = 0; k < 9; k++) begin
      p = '0;
      p.command = CMD_PIXEL;
      case (k)
        0, 4, 8: p = {CMD_PIXEL, 24'hFFFFFF};
        1: p.red = 8'hFF;
        3: p.green = 8'hFF;
        5: p.blue = 8'hFF;
        default: ;
      endcase
      queue_item(p);
    end
    queue_item(rand_pixel());
    for (int k = 0; k < 6; k++) queue_item(flush_beat());
    wait_drained();

    // zero registers act as a 1x1 image
    write_reg(CFG_WIDTH, CFG_W'(0));
    write_reg(CFG_HEIGHT, CFG_W'(0));
    queue_image(1, 1, 1'b0);
    wait_drained();

    // tallest height, abandoned mid-image by a register write
    write_reg(CFG_HEIGHT, 16'hFFFF);
    write_reg(CFG_WIDTH, CFG_W'(1));
    for (int k = 0; k < 20; k++) queue_item(rand_pixel());
    wait_drained();

    // width above the line store depth, part of the first row streamed without gaps, abandoned
    idle_on = 1'b0;
    write_reg(CFG_WIDTH, 16'hFFFF);
    write_reg(CFG_HEIGHT, CFG_W'(2));
    for (int k = 0; k < 150; k++) queue_item(rand_pixel());
    wait_drained();
    idle_on = 1'b1;

    while (beats_issued < 1550) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      h = $urandom_range(1, 6);
      write_reg(CFG_WIDTH, CFG_W'(w));
      write_reg(CFG_HEIGHT, CFG_W'(h));
      idle_on = $urandom_range(0, 3) != 0;
      queue_image(w, h, 1'b1);
      wait_drained();
    end

    $display("Covered %0d input beats and %0d result beats over %0d images,",
             beats_in, beats_out, images);
    $display("widths from 0 past the line store depth, heights from 0 to the maximum.");
    if (errors == 0) $display("[prewitt_edge_magnitude_filter] OK");
    else $display("[prewitt_edge_magnitude_filter] ERROR");
    $finish;
  end
endmodule
